// ===== src/aes256_ctr_byte_stream_top_macros.svh =====
// Assertion helpers for the byte stream block.
// Both take a label, an antecedent, a consequent and a message.
`ifndef AES256_CTR_BYTE_STREAM_TOP_MACROS_SVH
`define AES256_CTR_BYTE_STREAM_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ACBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/acbs_pkg.sv =====
// ----------------------------------------------------------------------------
// acbs_pkg
// Shared constants, types and AES round functions for the CTR byte stream.
// ----------------------------------------------------------------------------
package acbs_pkg;

    localparam int BLK_BYTES  = 16;
    localparam int BLK_BITS   = 128;
    localparam int KEY_BITS   = 256;
    localparam int KEY_WORDS  = 4;
    localparam int LAST_ROUND = 14;

    // Key register indexes
    localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [1:0] REG_KEY_WORD3 = 2'd3;

    typedef logic [BLK_BITS-1:0] t_block;
    typedef logic [KEY_BITS-1:0] t_key;

    // Keystream queue status towards its producer and consumer
    typedef struct packed {
        logic have_block;
        logic can_push;
    } t_ks_status;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] f_xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] f_subword(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns (not in last), AddRoundKey.
    // Byte i of a block sits in bits [127-8i -: 8].
    function automatic t_block f_round(input t_block s, input t_block rk, input logic last);
        logic [7:0] sb [16];
        logic [7:0] t  [16];
        logic [7:0] a0, a1, a2, a3, all;
        t_block     res;
        for (int i = 0; i < 16; i++) begin
            sb[i] = s[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r+4*c] = SBOX[sb[r+4*((c+r)%4)]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[4*c];
                a1  = t[4*c+1];
                a2  = t[4*c+2];
                a3  = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ f_xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ f_xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ f_xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ f_xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127-8*i -: 8] = t[i];
        end
        return res ^ rk;
    endfunction

endpackage

// ===== src/acbs_in_if.sv =====
// ----------------------------------------------------------------------------
// acbs_in_if
// Data byte request channel into the block.
// ----------------------------------------------------------------------------
interface acbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/acbs_out_if.sv =====
// ----------------------------------------------------------------------------
// acbs_out_if
// Result byte request channel out of the block.
// ----------------------------------------------------------------------------
interface acbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== src/aes256_ctr_byte_stream_top.sv =====
// ----------------------------------------------------------------------------
// aes256_ctr_byte_stream_top
// AES-256 counter-mode byte stream: each data byte request returns one byte
// XORed with the next keystream byte. The AES unit runs one round per cycle
// and turns out keystream blocks into a two-block queue faster than the byte
// side uses up their 16 bytes, so the block sustains one byte per cycle while
// requests arrive and the result side is not stalled. After reset or a key
// write the first byte waits for the first block. Any key register write
// restarts the stream from counter zero.
// ----------------------------------------------------------------------------
`include "aes256_ctr_byte_stream_top_macros.svh"

module aes256_ctr_byte_stream_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    acbs_in_if.sink     i_data_ch,
    acbs_out_if.source  o_res_ch
);

    acbs_pkg::t_ks_status status;
    acbs_pkg::t_block     ks_block;
    acbs_pkg::t_block     head;
    logic                 ks_push;
    logic                 pop;

    // Keystream generator
    acbs_ks_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_status   (status),
        .o_push     (ks_push),
        .o_block    (ks_block)
    );

    // Keystream queue
    acbs_ks_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flush  (i_cfg_we),
        .i_push   (ks_push),
        .i_block  (ks_block),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    // Byte side
    acbs_byte_xor u_xor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (i_cfg_we),
        .i_status  (status),
        .i_head    (head),
        .o_pop     (pop),
        .i_data_ch (i_data_ch),
        .o_res_ch  (o_res_ch)
    );

    `ACBS_ASSERT_NOW(a_push_room, ks_push, status.can_push, "keystream pushed into full queue")
    `ACBS_ASSERT_NOW(a_pop_data, pop, status.have_block, "keystream popped from empty queue")
    `ACBS_ASSERT_NEXT(a_key_flush, i_cfg_we, !i_data_ch.ready, "byte taken right after key write")

endmodule

// ===== src/acbs_ks_engine.sv =====
// ----------------------------------------------------------------------------
// acbs_ks_engine
// Key store, CTR counter and iterative AES-256 unit, one round per cycle,
// with the key schedule expanded on the fly.
// ----------------------------------------------------------------------------
module acbs_ks_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  acbs_pkg::t_ks_status  i_status,
    output logic                  o_push,
    output acbs_pkg::t_block      o_block
);

    acbs_pkg::t_key   r_key;
    acbs_pkg::t_block r_ctr;
    acbs_pkg::t_block r_state;
    acbs_pkg::t_key   r_win;
    logic [3:0]       r_round;
    logic             r_busy;

    acbs_pkg::t_block n_state;
    acbs_pkg::t_block n_rk;
    logic             last;
    logic [31:0]      tw;
    logic [31:0]      w0, w1, w2, w3;

    // Round datapath and next round key from the two-key window
    always_comb begin
        last    = (r_round == 4'(acbs_pkg::LAST_ROUND));
        n_state = acbs_pkg::f_round(r_state, r_win[127:0], last);
        if (r_round[0]) begin
            tw = acbs_pkg::f_subword({r_win[23:0], r_win[31:24]})
                 ^ {8'h01 << r_round[3:1], 24'h0};
        end else begin
            tw = acbs_pkg::f_subword(r_win[31:0]);
        end
        w0   = r_win[255:224] ^ tw;
        w1   = r_win[223:192] ^ w0;
        w2   = r_win[191:160] ^ w1;
        w3   = r_win[159:128] ^ w2;
        n_rk = {w0, w1, w2, w3};
    end

    assign o_push  = r_busy && last;
    assign o_block = n_state;

    // Control: key writes restart the stream and abort any block in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_ctr   <= '0;
            r_busy  <= 1'b0;
            r_round <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                acbs_pkg::REG_KEY_WORD0: r_key[255:192] <= i_cfg_data;
                acbs_pkg::REG_KEY_WORD1: r_key[191:128] <= i_cfg_data;
                acbs_pkg::REG_KEY_WORD2: r_key[127:64]  <= i_cfg_data;
                acbs_pkg::REG_KEY_WORD3: r_key[63:0]    <= i_cfg_data;
                default: ;
            endcase
            r_ctr  <= '0;
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_status.can_push) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
                r_ctr   <= r_ctr + 1'b1;
            end
        end else if (last) begin
            r_busy <= 1'b0;
        end else begin
            r_round <= r_round + 4'd1;
        end
    end

    // Datapath: load whitened counter, then advance one round a cycle
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_state <= r_ctr ^ r_key[255:128];
            r_win   <= r_key;
        end else begin
            r_state <= n_state;
            r_win   <= {r_win[127:0], n_rk};
        end
    end

endmodule

// ===== src/acbs_ks_fifo.sv =====
// ----------------------------------------------------------------------------
// acbs_ks_fifo
// Two-block keystream queue between the AES unit and the byte side.
// ----------------------------------------------------------------------------
module acbs_ks_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_flush,
    input  logic                  i_push,
    input  acbs_pkg::t_block      i_block,
    input  logic                  i_pop,
    output acbs_pkg::t_block      o_head,
    output acbs_pkg::t_ks_status  o_status
);

    acbs_pkg::t_block r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    assign o_head              = r_mem[r_rp];
    assign o_status.have_block = (r_cnt != 2'd0);
    assign o_status.can_push   = (r_cnt != 2'd2);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Block storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_block;
        end
    end

endmodule

// ===== src/acbs_byte_xor.sv =====
// ----------------------------------------------------------------------------
// acbs_byte_xor
// Byte side: takes data byte requests, XORs the next keystream byte and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module acbs_byte_xor (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_flush,
    input  acbs_pkg::t_ks_status  i_status,
    input  acbs_pkg::t_block      i_head,
    output logic                  o_pop,
    acbs_in_if.sink               i_data_ch,
    acbs_out_if.source            o_res_ch
);

    logic [3:0] r_off;
    logic       r_oval;
    logic [7:0] r_obyte;

    logic       take;
    logic [6:0] bsel;

    assign i_data_ch.ready = i_status.have_block && (!r_oval || o_res_ch.ready);
    assign take            = i_data_ch.valid && i_data_ch.ready;
    assign bsel            = {~r_off, 3'b000};
    assign o_pop           = take && (r_off == 4'(acbs_pkg::BLK_BYTES - 1));

    assign o_res_ch.valid    = r_oval;
    assign o_res_ch.out_byte = r_obyte;

    // Offset into the head block and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_oval <= 1'b0;
        end else begin
            if (i_flush) begin
                r_off <= '0;
            end else if (take) begin
                r_off <= r_off + 4'd1;
            end
            if (take) begin
                r_oval <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Result byte
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_obyte <= i_data_ch.data_byte ^ i_head[bsel +: 8];
        end
    end

endmodule

// ===== tb/tb_aes256_ctr_byte_stream_top.sv =====
// ----------------------------------------------------------------------------
// tb_aes256_ctr_byte_stream_top
// Drives data byte requests through the AES-256-CTR byte stream and checks
// every result byte against an in-bench keystream predictor. Key words are
// rewritten between phases (all zeros, all ones, random, partial rewrites,
// restart part way through a block), with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_aes256_ctr_byte_stream_top;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    acbs_in_if  data_ch ();
    acbs_out_if res_ch ();

    aes256_ctr_byte_stream_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data_ch  (data_ch.sink),
        .o_res_ch   (res_ch.source)
    );

    // Stream predictor state
    logic [63:0]       key_regs [acbs_pkg::KEY_WORDS];
    acbs_pkg::t_block  ctr_block;
    acbs_pkg::t_block  ks_block;
    int unsigned       ks_offset;

    logic [7:0]    byte_queue[$];
    logic [7:0]    expected_bytes[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   key_writes;
    int unsigned   cycle_count;
    logic          quiet_span;
    logic          in_taken;

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypt one counter block under the current key
    function automatic acbs_pkg::t_block aes256_block(input acbs_pkg::t_block pt);
        logic [31:0]      w [60];
        logic [31:0]      tmp;
        logic [7:0]       rc;
        logic [7:0]       s [16];
        logic [7:0]       t [16];
        logic [7:0]       a0, a1, a2, a3, x;
        acbs_pkg::t_block res;
        for (int i = 0; i < 8; i++) begin
            w[i] = key_regs[i/2][63-32*(i%2) -: 32];
        end
        rc = 8'h01;
        for (int i = 8; i < 60; i++) begin
            tmp = w[i-1];
            if (i % 8 == 0) begin
                tmp = {acbs_pkg::SBOX[tmp[23:16]] ^ rc, acbs_pkg::SBOX[tmp[15:8]],
                       acbs_pkg::SBOX[tmp[7:0]], acbs_pkg::SBOX[tmp[31:24]]};
                rc  = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end else if (i % 8 == 4) begin
                tmp = {acbs_pkg::SBOX[tmp[31:24]], acbs_pkg::SBOX[tmp[23:16]],
                       acbs_pkg::SBOX[tmp[15:8]], acbs_pkg::SBOX[tmp[7:0]]};
            end
            w[i] = w[i-8] ^ tmp;
        end
        for (int i = 0; i < 16; i++) begin
            s[i] = pt[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
        end
        for (int rnd = 1; rnd <= acbs_pkg::LAST_ROUND; rnd++) begin
            // substitute and shift rows
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    t[r+4*c] = acbs_pkg::SBOX[s[r+4*((c+r)%4)]];
                end
            end
            // mix columns, skipped in the final round
            if (rnd != acbs_pkg::LAST_ROUND) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c];
                    a1 = t[4*c+1];
                    a2 = t[4*c+2];
                    a3 = t[4*c+3];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) begin
                s[i] = t[i] ^ w[4*rnd + i/4][31-8*(i%4) -: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127-8*i -: 8] = s[i];
        end
        return res;
    endfunction

    // Next output byte: refill keystream when exhausted, then advance
    function automatic logic [7:0] next_cipher_byte(input logic [7:0] d);
        logic [7:0] r;
        if (ks_offset >= acbs_pkg::BLK_BYTES) begin
            ks_block  = aes256_block(ctr_block);
            ctr_block = ctr_block + 1'b1;
            ks_offset = 0;
        end
        r = d ^ ks_block[127-8*ks_offset -: 8];
        ks_offset++;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Monitor: track requests, key writes and result bytes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && data_ch.valid && data_ch.ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                key_regs[i_cfg_idx] = i_cfg_data;
                ctr_block           = '0;
                ks_offset           = acbs_pkg::BLK_BYTES;
            end
            if (data_ch.valid && data_ch.ready) begin
                expected_bytes.push_back(next_cipher_byte(data_ch.data_byte));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected out_byte %02h", res_ch.out_byte));
                end else begin
                    checked++;
                    if (res_ch.out_byte !== expected_bytes[0]) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  res_ch.out_byte, expected_bytes[0]));
                    end
                    void'(expected_bytes.pop_front());
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Driver: hold a request until taken, idle at random outside the quiet span
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            data_ch.valid <= 1'b0;
            res_ch.ready  <= 1'b0;
        end else begin
            res_ch.ready <= quiet_span || ($urandom_range(99) >= 25);
            if (!data_ch.valid || in_taken) begin
                if (byte_queue.size() != 0 && (quiet_span || $urandom_range(99) >= 25)) begin
                    data_ch.valid     <= 1'b1;
                    data_ch.data_byte <= byte_queue.pop_front();
                end else begin
                    data_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        key_writes++;
    endtask

    // Let every queued request drain, then the keystream pipe settle
    task automatic drain();
        wait (byte_queue.size() == 0 && !data_ch.valid && expected_bytes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            byte_queue.push_back(8'($urandom));
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = acbs_pkg::REG_KEY_WORD0;
        i_cfg_data        = '0;
        data_ch.valid     = 1'b0;
        data_ch.data_byte = '0;
        res_ch.ready      = 1'b0;
        quiet_span        = 1'b0;
        in_taken          = 1'b0;
        cycle_count       = 0;
        mismatches        = 0;
        checked           = 0;
        key_writes        = 0;
        for (int i = 0; i < acbs_pkg::KEY_WORDS; i++) begin
            key_regs[i] = '0;
        end
        ctr_block = '0;
        ks_block  = '0;
        ks_offset = acbs_pkg::BLK_BYTES;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero key after reset: extremes and a block boundary crossing
        byte_queue = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80};
        for (int i = 0; i < 14; i++) begin
            byte_queue.push_back(8'(i * 17));
        end
        drain();

        // All-ones key, then restart part way through a block
        write_key(acbs_pkg::REG_KEY_WORD0, '1);
        write_key(acbs_pkg::REG_KEY_WORD1, '1);
        write_key(acbs_pkg::REG_KEY_WORD2, '1);
        write_key(acbs_pkg::REG_KEY_WORD3, '1);
        byte_queue = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h5a};
        drain();
        write_key(acbs_pkg::REG_KEY_WORD2, 64'h0123_4567_89ab_cdef);
        byte_queue = '{8'hff, 8'h00, 8'h3c};
        drain();

        // Random phases: full or partial key rewrites, one span without stalls
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                for (int k = 0; k < acbs_pkg::KEY_WORDS; k++) begin
                    write_key(2'(k), '0);
                end
            end else if (ph % 3 == 0) begin
                write_key(2'($urandom_range(3)), {$urandom, $urandom});
            end else begin
                for (int k = 0; k < acbs_pkg::KEY_WORDS; k++) begin
                    write_key(2'(k), {$urandom, $urandom});
                end
            end
            quiet_span = (ph == 4);
            queue_random(100 + $urandom_range(50));
            drain();
        end
        quiet_span = 1'b0;

        $display("checked %0d result bytes over %0d key register writes", checked, key_writes);
        $display("covered zero, all-ones and random keys, mid-block restarts and stalls");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/acbs_pkg.sv
src/acbs_in_if.sv
src/acbs_out_if.sv
src/acbs_ks_engine.sv
src/acbs_ks_fifo.sv
src/acbs_byte_xor.sv
src/aes256_ctr_byte_stream_top.sv
tb/tb_aes256_ctr_byte_stream_top.sv
